@@ rtl/core/jhe_pkg.sv @@
`timescale 1ns / 1ps
package jhe_pkg;

    localparam int QueueDepth = 2;

    localparam logic [7:0] ZRL_SYM = 8'hF0;
    localparam logic [7:0] EOB_SYM = 8'h00;
    localparam logic [7:0] STUFF_BYTE = 8'h00;
    localparam logic [7:0] MARK_BYTE = 8'hFF;

    typedef logic [20:0] ac_ent_t;
    typedef ac_ent_t ac_tab_t [256];
    typedef logic [7:0] cnt_arr_t [16];
    typedef logic [7:0] sym_arr_t [162];

    typedef struct packed {
        logic [1:0]  zrl_n;
        logic [15:0] zrl_code;
        logic [4:0]  zrl_len;
        logic [15:0] sym_code;
        logic [4:0]  sym_len;
        logic [10:0] mag;
        logic [3:0]  mag_len;
        logic        img_end;
        logic [6:0]  total;
    } job_t;

    localparam cnt_arr_t ACL_COUNTS = '{8'd0, 8'd2, 8'd1, 8'd3, 8'd3, 8'd2, 8'd4, 8'd3,
                                        8'd5, 8'd5, 8'd4, 8'd4, 8'd0, 8'd0, 8'd1, 8'h7d};
    localparam cnt_arr_t ACC_COUNTS = '{8'd0, 8'd2, 8'd1, 8'd2, 8'd4, 8'd4, 8'd3, 8'd4,
                                        8'd7, 8'd5, 8'd4, 8'd4, 8'd0, 8'd1, 8'd2, 8'h77};

    localparam sym_arr_t ACL_SYMS = '{
        8'h01,8'h02,8'h03,8'h00,8'h04,8'h11,8'h05,8'h12,8'h21,8'h31,8'h41,8'h06,8'h13,8'h51,
        8'h61,8'h07,8'h22,8'h71,8'h14,8'h32,8'h81,8'h91,8'ha1,8'h08,8'h23,8'h42,8'hb1,8'hc1,
        8'h15,8'h52,8'hd1,8'hf0,8'h24,8'h33,8'h62,8'h72,8'h82,8'h09,8'h0a,8'h16,8'h17,8'h18,
        8'h19,8'h1a,8'h25,8'h26,8'h27,8'h28,8'h29,8'h2a,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,
        8'h3a,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4a,8'h53,8'h54,8'h55,8'h56,8'h57,
        8'h58,8'h59,8'h5a,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6a,8'h73,8'h74,8'h75,
        8'h76,8'h77,8'h78,8'h79,8'h7a,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h8a,8'h92,
        8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,8'ha2,8'ha3,8'ha4,8'ha5,8'ha6,8'ha7,
        8'ha8,8'ha9,8'haa,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,8'hc2,8'hc3,
        8'hc4,8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,8'hca,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,8'hd8,
        8'hd9,8'hda,8'he1,8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hf1,8'hf2,
        8'hf3,8'hf4,8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'hfa};

    localparam sym_arr_t ACC_SYMS = '{
        8'h00,8'h01,8'h02,8'h03,8'h11,8'h04,8'h05,8'h21,8'h31,8'h06,8'h12,8'h41,8'h51,8'h07,
        8'h61,8'h71,8'h13,8'h22,8'h32,8'h81,8'h08,8'h14,8'h42,8'h91,8'ha1,8'hb1,8'hc1,8'h09,
        8'h23,8'h33,8'h52,8'hf0,8'h15,8'h62,8'h72,8'hd1,8'h0a,8'h16,8'h24,8'h34,8'he1,8'h25,
        8'hf1,8'h17,8'h18,8'h19,8'h1a,8'h26,8'h27,8'h28,8'h29,8'h2a,8'h35,8'h36,8'h37,8'h38,
        8'h39,8'h3a,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4a,8'h53,8'h54,8'h55,8'h56,
        8'h57,8'h58,8'h59,8'h5a,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6a,8'h73,8'h74,
        8'h75,8'h76,8'h77,8'h78,8'h79,8'h7a,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,
        8'h8a,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,8'ha2,8'ha3,8'ha4,8'ha5,
        8'ha6,8'ha7,8'ha8,8'ha9,8'haa,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,
        8'hc2,8'hc3,8'hc4,8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,8'hca,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,
        8'hd7,8'hd8,8'hd9,8'hda,8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hf2,
        8'hf3,8'hf4,8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'hfa};

    // canonical code assignment, evaluated at elaboration
    function automatic ac_tab_t build_ac(input cnt_arr_t counts, input sym_arr_t syms);
        ac_tab_t tab;
        int code;
        int pos;
        for (int i = 0; i < 256; i++) tab[i] = '0;
        code = 0;
        pos = 0;
        for (int len = 1; len <= 16; len++) begin
            for (int i = 0; i < int'(counts[len-1]); i++) begin
                if (pos < 162) begin
                    tab[syms[pos]] = {5'(len), 16'(code)};
                    pos++;
                    code++;
                end
            end
            code = code << 1;
        end
        return tab;
    endfunction

    localparam ac_tab_t ACL_TAB = build_ac(ACL_COUNTS, ACL_SYMS);
    localparam ac_tab_t ACC_TAB = build_ac(ACC_COUNTS, ACC_SYMS);

    // dc code {len, code} for size category s
    function automatic ac_ent_t dc_code(input logic chroma, input logic [3:0] s);
        logic [4:0]  len;
        logic [15:0] code;
        if (chroma) begin
            if (s <= 4'd2) begin
                len = 5'd2;
                code = {12'd0, s};
            end else begin
                len = {1'b0, s};
                code = (16'd1 << s) - 16'd2;
            end
        end else begin
            if (s == 4'd0) begin
                len = 5'd2;
                code = 16'd0;
            end else if (s <= 4'd5) begin
                len = 5'd3;
                code = {12'd0, s} + 16'd1;
            end else begin
                len = {1'b0, s} - 5'd2;
                code = (16'd1 << (s - 4'd2)) - 16'd2;
            end
        end
        return {len, code};
    endfunction

    function automatic logic [3:0] size_of(input logic [10:0] a);
        logic [3:0] s;
        s = 4'd0;
        for (int i = 0; i < 11; i++) begin
            if (a[i]) s = 4'(i + 1);
        end
        return s;
    endfunction

endpackage

@@ rtl/core/jhe_front.sv @@
`timescale 1ns / 1ps
module jhe_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  logic signed [10:0]  coeff_value,
    input  logic [1:0]          component,
    input  logic                image_end,
    output jhe_pkg::job_t       job
);

    logic [5:0]  pos_reg, pos_next;
    logic [5:0]  run_reg, run_next;
    logic [10:0] pred_reg [3];
    logic [1:0]  comp;
    logic        chroma;
    logic [11:0] diff;
    logic [11:0] dabs;
    logic [11:0] dmag;
    logic [11:0] dmask;
    logic [3:0]  dsize;
    logic [10:0] acv;
    logic [10:0] aabs;
    logic [10:0] amag;
    logic [10:0] amask;
    logic [3:0]  asize;
    logic [5:0]  run_tot;
    logic [7:0]  ac_sym;
    jhe_pkg::ac_ent_t sym_ent;
    jhe_pkg::ac_ent_t zrl_ent;
    jhe_pkg::ac_ent_t dc_ent;
    logic        eob;
    logic [6:0]  zrl_bits;

    assign comp = (component == 2'd3) ? 2'd2 : component;
    assign chroma = (comp != 2'd0);

    always_comb begin
        diff = {coeff_value[10], coeff_value} - {pred_reg[comp][10], pred_reg[comp]};
        dabs = diff[11] ? (12'd0 - diff) : diff;
        dsize = jhe_pkg::size_of(dabs[10:0]);
        if (dabs[11]) dsize = 4'd12;
        dmask = (12'd1 << dsize) - 12'd1;
        dmag = (diff[11] ? (diff - 12'd1) : diff) & dmask;
        dc_ent = jhe_pkg::dc_code(chroma, dsize);

        // -1024 has no ac category, saturate
        acv = (coeff_value == 11'sh400) ? 11'h401 : coeff_value;
        aabs = acv[10] ? (11'd0 - acv) : acv;
        asize = jhe_pkg::size_of(aabs);
        amask = (11'd1 << asize) - 11'd1;
        amag = (acv[10] ? (acv - 11'd1) : acv) & amask;

        eob = (coeff_value == '0) && (pos_reg == 6'd63);
        ac_sym = eob ? jhe_pkg::EOB_SYM : {2'b00, run_reg[3:0], asize[1:0]};
        ac_sym[7:4] = eob ? 4'd0 : run_reg[3:0];
        ac_sym[3:0] = eob ? 4'd0 : asize;
        sym_ent = chroma ? jhe_pkg::ACC_TAB[ac_sym] : jhe_pkg::ACL_TAB[ac_sym];
        zrl_ent = chroma ? jhe_pkg::ACC_TAB[jhe_pkg::ZRL_SYM]
                         : jhe_pkg::ACL_TAB[jhe_pkg::ZRL_SYM];

        job = '0;
        job.img_end = image_end;
        job.zrl_code = zrl_ent[15:0];
        job.zrl_len = zrl_ent[20:16];
        if (pos_reg == 6'd0) begin
            job.sym_code = dc_ent[15:0];
            job.sym_len = dc_ent[20:16];
            job.mag = dmag[10:0];
            job.mag_len = (dsize == 4'd12) ? 4'd11 : dsize;
        end else if (coeff_value != '0) begin
            job.zrl_n = run_reg[5:4];
            job.sym_code = sym_ent[15:0];
            job.sym_len = sym_ent[20:16];
            job.mag = amag;
            job.mag_len = asize;
        end else if (eob) begin
            job.sym_code = sym_ent[15:0];
            job.sym_len = sym_ent[20:16];
        end
        zrl_bits = 7'(job.zrl_n) * {2'b00, job.zrl_len};
        job.total = zrl_bits + {2'b00, job.sym_len} + {3'b000, job.mag_len};

        run_tot = (pos_reg == 6'd0 || coeff_value != '0) ? 6'd0 : run_reg + 6'd1;
        pos_next = pos_reg + 6'd1;
        run_next = (pos_next == 6'd0 || image_end) ? 6'd0 : run_tot;
        if (image_end) pos_next = 6'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            run_reg <= '0;
            for (int i = 0; i < 3; i++) pred_reg[i] <= '0;
        end else if (push) begin
            pos_reg <= pos_next;
            run_reg <= run_next;
            if (image_end) begin
                for (int i = 0; i < 3; i++) pred_reg[i] <= '0;
            end else if (pos_reg == 6'd0) begin
                pred_reg[comp] <= coeff_value;
            end
        end
    end

endmodule

@@ rtl/core/jhe_queue.sv @@
`timescale 1ns / 1ps
module jhe_queue #(
    parameter int DEPTH = jhe_pkg::QueueDepth
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_en,
    input  jhe_pkg::job_t  wr_data,
    output logic           full,
    input  logic           rd_en,
    output jhe_pkg::job_t  rd_data,
    output logic           empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    jhe_pkg::job_t  mem_reg [DEPTH];
    logic [PW-1:0]  wp_reg, rp_reg;
    logic [CW-1:0]  cnt_reg;

    assign full = (cnt_reg == CW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (wr_en) mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr_en) wp_reg <= (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + PW'(1);
            if (rd_en) rp_reg <= (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + PW'(1);
            if (wr_en && !rd_en) cnt_reg <= cnt_reg + CW'(1);
            else if (rd_en && !wr_en) cnt_reg <= cnt_reg - CW'(1);
        end
    end

endmodule

@@ rtl/core/jhe_back.sv @@
`timescale 1ns / 1ps
module jhe_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_empty,
    input  jhe_pkg::job_t  q_data,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [7:0]     m_out_byte,
    output logic           m_last_of_run,
    output logic           m_scan_done
);

    jhe_pkg::job_t job_reg;
    logic        active_reg;
    logic [1:0]  zrl_left_reg;
    logic        sym_pend_reg, mag_pend_reg;
    logic [15:0] seg_reg;
    logic [4:0]  seg_left_reg;
    logic        seg_pad_reg;
    logic [6:0]  rem_reg;
    logic [7:0]  acc_reg;
    logic [3:0]  cnt_reg;
    logic        ov_reg;
    logic [7:0]  ob_reg;
    logic        ol_reg, od_reg;
    logic        stuff_reg, stuff_last_reg, stuff_done_reg;

    logic        out_free;
    logic [3:0]  room, k;
    logic [15:0] tmp;
    logic [7:0]  newacc;
    logic [3:0]  cnt_sum;
    logic [6:0]  rem_after;
    logic        is_last;
    logic        step;
    logic        byte_out;

    assign out_free = !ov_reg || m_ready;
    assign q_pop = !active_reg && !q_empty;
    assign step = active_reg && (seg_left_reg != '0) && out_free && !stuff_reg;

    always_comb begin
        room = 4'd8 - cnt_reg;
        k = (seg_left_reg < {1'b0, room}) ? seg_left_reg[3:0] : room;
        tmp = ({8'd0, acc_reg} << k) | {8'd0, (seg_reg[15:8] >> (4'd8 - k))};
        newacc = tmp[7:0];
        cnt_sum = cnt_reg + k;
        rem_after = seg_pad_reg ? rem_reg : rem_reg - {3'b000, k};
        is_last = seg_pad_reg ||
                  !((rem_after >= 7'd8) || (job_reg.img_end && rem_after != '0));
    end

    // a new output beat is loaded by a stuffed zero or by a completed byte
    assign byte_out = (stuff_reg && out_free) || (step && cnt_sum == 4'd8);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            seg_left_reg <= '0;
            acc_reg <= '0;
            cnt_reg <= '0;
            ov_reg <= 1'b0;
            stuff_reg <= 1'b0;
            zrl_left_reg <= '0;
            sym_pend_reg <= 1'b0;
            mag_pend_reg <= 1'b0;
            seg_pad_reg <= 1'b0;
            rem_reg <= '0;
        end else begin
            if (byte_out) ov_reg <= 1'b1;
            else if (m_ready) ov_reg <= 1'b0;
            if (stuff_reg && out_free) begin
                ob_reg <= jhe_pkg::STUFF_BYTE;
                ol_reg <= stuff_last_reg;
                od_reg <= stuff_done_reg;
                stuff_reg <= 1'b0;
            end
            if (q_pop) begin
                job_reg <= q_data;
                active_reg <= 1'b1;
                zrl_left_reg <= q_data.zrl_n;
                sym_pend_reg <= (q_data.sym_len != '0);
                mag_pend_reg <= (q_data.mag_len != '0);
                rem_reg <= q_data.total;
            end else if (active_reg && seg_left_reg == '0) begin
                seg_pad_reg <= 1'b0;
                // next code segment of this item, left aligned
                priority if (zrl_left_reg != '0) begin
                    seg_reg <= job_reg.zrl_code << (5'd16 - job_reg.zrl_len);
                    seg_left_reg <= job_reg.zrl_len;
                    zrl_left_reg <= zrl_left_reg - 2'd1;
                end else if (sym_pend_reg) begin
                    seg_reg <= job_reg.sym_code << (5'd16 - job_reg.sym_len);
                    seg_left_reg <= job_reg.sym_len;
                    sym_pend_reg <= 1'b0;
                end else if (mag_pend_reg) begin
                    seg_reg <= {job_reg.mag, 5'd0} << (4'd11 - job_reg.mag_len);
                    seg_left_reg <= {1'b0, job_reg.mag_len};
                    mag_pend_reg <= 1'b0;
                end else if (job_reg.img_end && cnt_reg != '0) begin
                    seg_reg <= 16'hFFFF;
                    seg_left_reg <= {1'b0, room};
                    seg_pad_reg <= 1'b1;
                end else begin
                    active_reg <= 1'b0;
                end
            end else if (step) begin
                seg_reg <= seg_reg << k;
                seg_left_reg <= seg_left_reg - {1'b0, k};
                rem_reg <= rem_after;
                if (cnt_sum == 4'd8) begin
                    acc_reg <= '0;
                    cnt_reg <= '0;
                    ob_reg <= newacc;
                    if (newacc == jhe_pkg::MARK_BYTE) begin
                        ol_reg <= 1'b0;
                        od_reg <= 1'b0;
                        stuff_reg <= 1'b1;
                        stuff_last_reg <= is_last;
                        stuff_done_reg <= is_last && job_reg.img_end;
                    end else begin
                        ol_reg <= is_last;
                        od_reg <= is_last && job_reg.img_end;
                    end
                end else begin
                    acc_reg <= newacc;
                    cnt_reg <= cnt_sum;
                end
            end
        end
    end

    assign m_valid = ov_reg;
    assign m_out_byte = ob_reg;
    assign m_last_of_run = ol_reg;
    assign m_scan_done = od_reg;

endmodule

@@ rtl/core/jpeg_huffman_entropy_encoder_unit.sv @@
`timescale 1ns / 1ps
// a coefficient's job is registered in the job queue, popped into the back end, cut into code
// segments (zrl, symbol, magnitude, pad) and packed in chunks of up to eight bits into bytes
// the back end pops a new job only after it has wrapped up the previous one; a stuffed byte
// and output back-pressure stall the bit packer
// the front takes a beat whenever the job queue has room
// reset: synchronous active-low aresetn clears predictors, scan state and bit packer
module jpeg_huffman_entropy_encoder_unit #(
    parameter int QUEUE_DEPTH = jhe_pkg::QueueDepth
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [10:0] s_coeff_value,
    input  logic [1:0]         s_component,
    input  logic               s_image_end,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_byte,
    output logic               m_last_of_run,
    output logic               m_scan_done
);

    jhe_pkg::job_t wjob, rjob;
    logic full, empty, pop, push;

    assign s_ready = !full;
    assign push = s_valid && !full;

    jhe_front u_front (
        .aclk(aclk), .aresetn(aresetn), .push(push),
        .coeff_value(s_coeff_value), .component(s_component),
        .image_end(s_image_end), .job(wjob)
    );

    jhe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk(aclk), .aresetn(aresetn), .wr_en(push), .wr_data(wjob), .full(full),
        .rd_en(pop), .rd_data(rjob), .empty(empty)
    );

    jhe_back u_back (
        .aclk(aclk), .aresetn(aresetn), .q_empty(empty), .q_data(rjob), .q_pop(pop),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_byte(m_out_byte),
        .m_last_of_run(m_last_of_run), .m_scan_done(m_scan_done)
    );

endmodule
